@@ sv/jpe_pkg.sv @@
// package: types, constants and graph helper functions for the join pair enumerator
`default_nettype none
package jpe_pkg;

  localparam int RELATIONS = 6;
  localparam int NODE_W    = $clog2(RELATIONS);
  localparam int CNT_W     = $clog2(RELATIONS + 1);
  localparam int STK_D     = RELATIONS * (RELATIONS - 1) / 2;
  localparam int SP_W      = $clog2(STK_D + 1);
  localparam int STK_IW    = $clog2(STK_D);
  localparam int SETS      = 2 ** RELATIONS;

  typedef logic [RELATIONS-1:0] mask_t;
  typedef logic [NODE_W-1:0]    node_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [SP_W-1:0]      sp_t;
  typedef mask_t [RELATIONS-1:0] adj_t;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_ENUM  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] first_relation;
    logic [2:0] second_relation;
    logic [5:0] relation_set;
  } in_word_t;

  typedef struct packed {
    logic [5:0] left_part;
    logic [5:0] right_part;
    logic       none_found;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic root;
    logic step;
    logic pop;
    logic blk;
    logic chk1;
    logic chk2;
    logic emit;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_enum;
    logic root_found;
    logic root_done;
    logic need_pop;
    logic pop_end;
    logic blk_end;
    logic lb_zero;
    logic ok1;
    logic ok2;
    logic out_free;
  } dp_sts_t;

  function automatic mask_t nbrs(adj_t adj, mask_t s);
    mask_t r;
    r = '0;
    for (int i = 0; i < RELATIONS; i++) begin
      if (s[i]) r = r | adj[i];
    end
    return r;
  endfunction

  function automatic mask_t closure(adj_t adj, mask_t seeds, mask_t allowed);
    mask_t v;
    v = seeds & allowed;
    for (int k = 0; k < RELATIONS - 1; k++) begin
      v = v | (nbrs(adj, v) & allowed);
    end
    return v;
  endfunction

  function automatic logic connected(adj_t adj, mask_t s);
    mask_t lowbit;
    lowbit = s & (~s + mask_t'(1));
    return (s != '0) && (closure(adj, lowbit, s) == s);
  endfunction

  function automatic logic across(adj_t adj, mask_t a, mask_t b);
    return (nbrs(adj, a) & b) != '0;
  endfunction

endpackage
`default_nettype wire

@@ sv/jpe_ctrl.sv @@
// controller state machine sequencing search, block split checks and output
`default_nettype none
module jpe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  jpe_pkg::dp_sts_t    sts_i,
  output jpe_pkg::ctrl_cmd_t  cmd_o,
  output logic                in_ready_o
);
  import jpe_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_ROOT   = 9'b000000010,
    ST_STEP   = 9'b000000100,
    ST_POP    = 9'b000001000,
    ST_BLK    = 9'b000010000,
    ST_CHK1   = 9'b000100000,
    ST_CHK2   = 9'b001000000,
    ST_EMIT   = 9'b010000000,
    ST_FINISH = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.in_enum) state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cmd_o.root = 1'b1;
        state_d = sts_i.root_found ? ST_STEP : ST_BLK;
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        if (sts_i.root_done) state_d = ST_ROOT;
        else if (sts_i.need_pop) state_d = ST_POP;
      end
      ST_POP: begin
        cmd_o.pop = 1'b1;
        if (sts_i.pop_end) state_d = ST_STEP;
      end
      ST_BLK: begin
        cmd_o.blk = 1'b1;
        state_d = sts_i.blk_end ? ST_FINISH : ST_CHK1;
      end
      ST_CHK1: begin
        cmd_o.chk1 = 1'b1;
        if (sts_i.lb_zero) state_d = ST_BLK;
        else if (sts_i.ok1) state_d = ST_CHK2;
      end
      ST_CHK2: begin
        cmd_o.chk2 = 1'b1;
        state_d = sts_i.ok2 ? ST_EMIT : ST_CHK1;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.out_free) state_d = ST_CHK1;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/jpe_dp.sv @@
// datapath: graph, depth-first search registers, edge stack, split checks, output word
`default_nettype none
module jpe_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  jpe_pkg::in_word_t   in_word_i,
  input  jpe_pkg::ctrl_cmd_t  cmd_i,
  output jpe_pkg::dp_sts_t    sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output jpe_pkg::out_word_t  out_word_o
);
  import jpe_pkg::*;

  adj_t      adj_q;
  mask_t     set_q;
  cnt_t      disc_q [RELATIONS];
  cnt_t      low_q  [RELATIONS];
  cnt_t      iter_q [RELATIONS];
  node_t     par_q  [RELATIONS];
  logic [RELATIONS-1:0] isroot_q;
  cnt_t      clk_q;
  node_t     u_q, cu_q;
  node_t     stk_a_q [STK_D];
  node_t     stk_b_q [STK_D];
  sp_t       sp_q;
  mask_t     acc_q;
  mask_t     blocks_q [RELATIONS];
  cnt_t      nblk_q, bidx_q;
  mask_t     blk_q, lb_q, left_q;
  logic [SETS-1:0] emitted_q;
  logic      pend_valid_q;
  mask_t     pend_l_q, pend_r_q;
  logic      out_valid_q;
  out_word_t out_q;

  // combinational views
  mask_t  visited, cand, nb_u, rb, right_c, acc_c;
  node_t  root_n, v_n, p_n, top_a, top_b;
  cnt_t   it_u;
  logic   it_done, v_adj, v_new, v_back, pop_match;
  logic   out_load;
  logic [STK_IW-1:0] top_i, push_i;

  always_comb begin
    for (int i = 0; i < RELATIONS; i++) visited[i] = (disc_q[i] != '0);
    cand   = set_q & ~visited;
    root_n = '0;
    for (int i = RELATIONS - 1; i >= 0; i--) begin
      if (cand[i]) root_n = NODE_W'(i);
    end
    it_u    = iter_q[u_q];
    it_done = (it_u == CNT_W'(RELATIONS));
    v_n     = NODE_W'(it_u);
    p_n     = par_q[u_q];
    nb_u    = adj_q[u_q] & set_q;
    v_adj   = !it_done && nb_u[v_n];
    v_new   = v_adj && (disc_q[v_n] == '0);
    v_back  = v_adj && !v_new && (isroot_q[u_q] || v_n != p_n) &&
              (disc_q[v_n] < disc_q[u_q]);
    top_i   = STK_IW'(sp_q - 1'b1);
    push_i  = STK_IW'(sp_q);
    top_a   = stk_a_q[top_i];
    top_b   = stk_b_q[top_i];
    acc_c   = acc_q | (mask_t'(1) << top_a) | (mask_t'(1) << top_b);
    pop_match = ((top_a == u_q) && (top_b == cu_q)) || ((top_a == cu_q) && (top_b == u_q));
    rb      = blk_q ^ lb_q;
    right_c = set_q ^ left_q;
  end

  always_comb begin
    sts_o            = '0;
    sts_o.in_enum    = in_valid_i && (in_word_i.command == CMD_ENUM);
    sts_o.root_found = (cand != '0);
    sts_o.root_done  = it_done && isroot_q[u_q];
    sts_o.need_pop   = it_done && !isroot_q[u_q] && (low_q[u_q] >= disc_q[p_n]);
    sts_o.pop_end    = pop_match || (sp_q == SP_W'(1));
    sts_o.blk_end    = (bidx_q == nblk_q);
    sts_o.lb_zero    = (lb_q == '0);
    sts_o.ok1        = connected(adj_q, lb_q) && connected(adj_q, rb) &&
                       across(adj_q, lb_q, rb);
    sts_o.ok2        = connected(adj_q, left_q) && connected(adj_q, right_c) &&
                       across(adj_q, left_q, right_c) && !emitted_q[left_q];
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign out_load    = sts_o.out_free && ((cmd_i.emit && pend_valid_q) || cmd_i.finish);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_q        <= '0;
      set_q        <= '0;
      isroot_q     <= '0;
      clk_q        <= '0;
      u_q          <= '0;
      cu_q         <= '0;
      sp_q         <= '0;
      acc_q        <= '0;
      nblk_q       <= '0;
      bidx_q       <= '0;
      blk_q        <= '0;
      lb_q         <= '0;
      left_q       <= '0;
      emitted_q    <= '0;
      pend_valid_q <= 1'b0;
      pend_l_q     <= '0;
      pend_r_q     <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
      for (int i = 0; i < RELATIONS; i++) begin
        disc_q[i]   <= '0;
        low_q[i]    <= '0;
        iter_q[i]   <= '0;
        par_q[i]    <= '0;
        blocks_q[i] <= '0;
      end
      for (int i = 0; i < STK_D; i++) begin
        stk_a_q[i] <= '0;
        stk_b_q[i] <= '0;
      end
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      if (cmd_i.accept) begin
        case (in_word_i.command)
          CMD_CLEAR: adj_q <= '0;
          CMD_ADD: begin
            if ((in_word_i.first_relation < 3'(RELATIONS)) &&
                (in_word_i.second_relation < 3'(RELATIONS)) &&
                (in_word_i.first_relation != in_word_i.second_relation)) begin
              adj_q[NODE_W'(in_word_i.first_relation)][NODE_W'(in_word_i.second_relation)]
                <= 1'b1;
              adj_q[NODE_W'(in_word_i.second_relation)][NODE_W'(in_word_i.first_relation)]
                <= 1'b1;
            end
          end
          CMD_ENUM: begin
            set_q        <= mask_t'(in_word_i.relation_set);
            clk_q        <= '0;
            nblk_q       <= '0;
            bidx_q       <= '0;
            emitted_q    <= '0;
            pend_valid_q <= 1'b0;
            for (int i = 0; i < RELATIONS; i++) disc_q[i] <= '0;
          end
          default: ;
        endcase
      end

      if (cmd_i.root && (cand != '0)) begin
        clk_q            <= clk_q + 1'b1;
        disc_q[root_n]   <= clk_q + 1'b1;
        low_q[root_n]    <= clk_q + 1'b1;
        isroot_q[root_n] <= 1'b1;
        iter_q[root_n]   <= '0;
        u_q              <= root_n;
        sp_q             <= '0;
      end

      if (cmd_i.step) begin
        if (it_done) begin
          if (!isroot_q[u_q]) begin
            if (low_q[u_q] < low_q[p_n]) low_q[p_n] <= low_q[u_q];
            iter_q[p_n] <= iter_q[p_n] + 1'b1;
            u_q         <= p_n;
            cu_q        <= u_q;
            acc_q       <= '0;
          end
        end else if (v_new) begin
          stk_a_q[push_i] <= u_q;
          stk_b_q[push_i] <= v_n;
          sp_q            <= sp_q + 1'b1;
          clk_q           <= clk_q + 1'b1;
          disc_q[v_n]     <= clk_q + 1'b1;
          low_q[v_n]      <= clk_q + 1'b1;
          par_q[v_n]      <= u_q;
          isroot_q[v_n]   <= 1'b0;
          iter_q[v_n]     <= '0;
          u_q             <= v_n;
        end else begin
          if (v_back) begin
            stk_a_q[push_i] <= u_q;
            stk_b_q[push_i] <= v_n;
            sp_q            <= sp_q + 1'b1;
            if (disc_q[v_n] < low_q[u_q]) low_q[u_q] <= disc_q[v_n];
          end
          iter_q[u_q] <= it_u + 1'b1;
        end
      end

      if (cmd_i.pop) begin
        sp_q  <= sp_q - 1'b1;
        acc_q <= acc_c;
        if (pop_match || (sp_q == SP_W'(1))) begin
          blocks_q[NODE_W'(nblk_q)] <= acc_c;
          nblk_q <= nblk_q + 1'b1;
        end
      end

      if (cmd_i.blk && (bidx_q != nblk_q)) begin
        blk_q <= blocks_q[NODE_W'(bidx_q)];
        lb_q  <= (blocks_q[NODE_W'(bidx_q)] - 1'b1) & blocks_q[NODE_W'(bidx_q)];
      end

      if (cmd_i.chk1) begin
        if (lb_q == '0) begin
          bidx_q <= bidx_q + 1'b1;
        end else begin
          left_q <= closure(adj_q, lb_q, set_q & ~rb);
          lb_q   <= (lb_q - 1'b1) & blk_q;
        end
      end

      if (cmd_i.chk2 && sts_o.ok2) emitted_q[left_q] <= 1'b1;

      if (cmd_i.emit && sts_o.out_free) begin
        if (pend_valid_q) begin
          out_q.left_part  <= pend_l_q;
          out_q.right_part <= pend_r_q;
          out_q.none_found <= 1'b0;
          out_q.last       <= 1'b0;
        end
        pend_valid_q <= 1'b1;
        pend_l_q     <= left_q;
        pend_r_q     <= right_c;
      end

      if (cmd_i.finish && sts_o.out_free) begin
        out_q.left_part  <= pend_valid_q ? pend_l_q : '0;
        out_q.right_part <= pend_valid_q ? pend_r_q : '0;
        out_q.none_found <= !pend_valid_q;
        out_q.last       <= 1'b1;
        pend_valid_q     <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/join_pair_enumerator.sv @@
// top level: join pair enumerator, controller plus datapath
//
// channel  dir  handshake              word
// in       in   in_valid_i/in_ready_o  command, first/second_relation, relation_set
// out      out  out_valid_o/out_ready_i left_part, right_part, none_found, last
//
// enumerate runs a depth-first search over the relations in the set, pops the edge stack
// into blocks, then checks each nonempty proper submask of each block as a left part
// (62 at most)
// asynchronous active-low reset empties the graph
// the out stage holds a word under stall; the search waits only when it must emit a pair or the last word
`default_nettype none
module join_pair_enumerator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  jpe_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output jpe_pkg::out_word_t out_word_o
);
  import jpe_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  jpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  jpe_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
`default_nettype wire
